@@ rtl/core/integer_to_ascii_formatter_macros.svh @@
// Assertion macros shared by the formatter's checker.
// Needs nothing else; the including file supplies clock and reset names.
`ifndef INTEGER_TO_ASCII_FORMATTER_MACROS_SVH
`define INTEGER_TO_ASCII_FORMATTER_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ITAF_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("itaf check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ITAF_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("itaf check failed");

`endif

@@ rtl/core/itaf_pkg.sv @@
// Shared types, codes and constants of the integer to ASCII formatter.
// No dependencies.
`timescale 1ns / 1ps

package itaf_pkg;

  localparam int VALUE_WIDTH_DEF = 32;
  localparam int MAX_DIGITS_DEF  = 11;
  localparam int DEC_SCALE       = 100000;
  localparam int LOG10_2_SCALED  = 30103;

  typedef enum logic [1:0] {
    ACT_BYTE = 2'd0,
    ACT_SDEC = 2'd1,
    ACT_UDEC = 2'd2,
    ACT_HEX  = 2'd3
  } action_t;

  localparam logic [7:0] CHR_MINUS = 8'h2d;

  localparam logic [7:0] HEX_CHARS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef struct packed {
    logic [1:0]  action;
    logic [7:0]  char_byte;
    logic [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
  } out_item_t;

  // Control from the sequencer to the digit shift registers.
  typedef struct packed {
    logic load;
    logic hex;
    logic dabble;
    logic shift;
  } digit_cmd_t;

  // Decimal digits needed for an unsigned value of w bits (elaboration only).
  function automatic int dec_digits(input int w);
    return (w * LOG10_2_SCALED) / DEC_SCALE + 1;
  endfunction

endpackage

@@ rtl/core/itaf_digits.sv @@
// Digit shift registers: bit-serial binary to BCD (shift and add 3) and
// nibble-serial digit read-out, most significant digit first. Uses itaf_pkg.
`timescale 1ns / 1ps

module itaf_digits #(
  parameter int VALUE_WIDTH = 32,
  parameter int NDEC        = 10
) (
  input  logic                     clk,
  input  itaf_pkg::digit_cmd_t     cmd,
  input  logic [VALUE_WIDTH-1:0]   load_val,
  output logic [3:0]               top_digit
);
  import itaf_pkg::*;

  localparam int DW = 4 * NDEC;

  logic [VALUE_WIDTH-1:0]    sh_r, sh_nxt;
  logic [DW-1:0]             dig_r, dig_nxt;
  logic [DW-1:0]             adj;
  logic [DW+VALUE_WIDTH-1:0] hex_ext;

  assign hex_ext   = {{DW{1'b0}}, load_val};
  assign top_digit = dig_r[DW-1 -: 4];

  // Each BCD digit of five or more gets 3 added ahead of the shift.
  always_comb begin
    for (int i = 0; i < NDEC; i++) begin
      adj[4*i +: 4] = dig_r[4*i +: 4] + ((dig_r[4*i +: 4] >= 4'd5) ? 4'd3 : 4'd0);
    end
  end

  always_comb begin
    sh_nxt  = sh_r;
    dig_nxt = dig_r;
    if (cmd.load) begin
      sh_nxt  = load_val;
      dig_nxt = cmd.hex ? hex_ext[DW-1:0] : '0;
    end else if (cmd.dabble) begin
      sh_nxt  = {sh_r[VALUE_WIDTH-2:0], 1'b0};
      dig_nxt = {adj[DW-2:0], sh_r[VALUE_WIDTH-1]};
    end else if (cmd.shift) begin
      dig_nxt = {dig_r[DW-5:0], 4'd0};
    end
  end

  always_ff @(posedge clk) begin
    sh_r  <= sh_nxt;
    dig_r <= dig_nxt;
  end

endmodule

@@ rtl/core/itaf_ctrl.sv @@
// Request sequencer and output register: takes one request, drives the digit
// shift registers, skips leading zeros and issues characters. Uses itaf_pkg.
`timescale 1ns / 1ps

module itaf_ctrl #(
  parameter int VALUE_WIDTH = 32,
  parameter int MAX_DIGITS  = 11,
  parameter int NDEC        = 10
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_stall,
  input  itaf_pkg::in_item_t      in_item,
  output logic                    out_valid,
  input  logic                    out_stall,
  output itaf_pkg::out_item_t     out_item,
  output itaf_pkg::digit_cmd_t    cmd,
  output logic [VALUE_WIDTH-1:0]  load_val,
  input  logic [3:0]              top_digit
);
  import itaf_pkg::*;

  localparam int BW = $clog2(VALUE_WIDTH + 1);
  localparam int RW = $clog2(NDEC + 1);
  localparam int CW = $clog2(MAX_DIGITS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_SIGN = 4'b0010,
    S_CONV = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [7:0]             pend_r, pend_nxt;
  logic                   pend_last_r, pend_last_nxt;
  logic [BW-1:0]          bitc_r, bitc_nxt;
  logic [RW-1:0]          remc_r, remc_nxt;
  logic [CW-1:0]          cnt_r, cnt_nxt;
  logic                   started_r, started_nxt;
  logic                   out_valid_r, out_valid_nxt;
  out_item_t              out_item_r, out_item_nxt;

  logic [VALUE_WIDTH+31:0] val_ext;
  logic [VALUE_WIDTH-1:0]  val_w;
  logic                    accept, neg, slot_free, last_pos, skip, at_limit;

  assign val_ext   = {{VALUE_WIDTH{1'b0}}, in_item.value};
  assign val_w     = val_ext[VALUE_WIDTH-1:0];
  assign accept    = in_valid && !in_stall;
  assign neg       = (in_item.action == ACT_SDEC) && val_w[VALUE_WIDTH-1];
  assign load_val  = neg ? (~val_w + VALUE_WIDTH'(1)) : val_w;
  assign slot_free = !out_valid_r || !out_stall;
  assign last_pos  = (remc_r == RW'(1));
  assign skip      = !started_r && (top_digit == 4'd0) && !last_pos;
  assign at_limit  = (cnt_r == CW'(MAX_DIGITS - 1));

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_comb begin
    state_nxt     = state_r;
    pend_nxt      = pend_r;
    pend_last_nxt = pend_last_r;
    bitc_nxt      = bitc_r;
    remc_nxt      = remc_r;
    cnt_nxt       = cnt_r;
    started_nxt   = started_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_item_nxt  = out_item_r;
    cmd           = '0;

    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          cnt_nxt     = '0;
          started_nxt = 1'b0;
          bitc_nxt    = BW'(VALUE_WIDTH);
          remc_nxt    = RW'(NDEC);
          cmd.load    = 1'b1;
          cmd.hex     = (in_item.action == ACT_HEX);
          if (in_item.action == ACT_BYTE) begin
            pend_nxt      = in_item.char_byte;
            pend_last_nxt = 1'b1;
            state_nxt     = S_SIGN;
          end else if (neg) begin
            pend_nxt      = CHR_MINUS;
            pend_last_nxt = 1'b0;
            state_nxt     = S_SIGN;
          end else if (in_item.action == ACT_HEX) begin
            state_nxt = S_EMIT;
          end else begin
            state_nxt = S_CONV;
          end
        end
      end
      S_SIGN: begin
        if (slot_free) begin
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{out_char: pend_r, last: pend_last_r};
          cnt_nxt       = CW'(1);
          state_nxt     = pend_last_r ? S_IDLE : S_CONV;
        end
      end
      S_CONV: begin
        cmd.dabble = 1'b1;
        bitc_nxt   = bitc_r - BW'(1);
        if (bitc_r == BW'(1)) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (skip) begin
          cmd.shift = 1'b1;
          remc_nxt  = remc_r - RW'(1);
        end else if (slot_free) begin
          cmd.shift     = 1'b1;
          remc_nxt      = remc_r - RW'(1);
          started_nxt   = 1'b1;
          cnt_nxt       = cnt_r + CW'(1);
          out_valid_nxt = 1'b1;
          out_item_nxt  = '{out_char: HEX_CHARS[top_digit], last: last_pos || at_limit};
          if (last_pos || at_limit) begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
    pend_r      <= pend_nxt;
    pend_last_r <= pend_last_nxt;
    bitc_r      <= bitc_nxt;
    remc_r      <= remc_nxt;
    cnt_r       <= cnt_nxt;
    started_r   <= started_nxt;
    out_item_r  <= out_item_nxt;
  end

endmodule

@@ rtl/core/integer_to_ascii_formatter.sv @@
// Integer to ASCII formatter, top level. One request in flight at a time.
// Byte: the byte passes through the sign state into the output register. Hex: the
// NDEC digits are read out. Decimal: the value is shifted bit-serially through the BCD
// converter, then the NDEC digits are read out (after a minus sign for a negative
// signed value); one character per cycle at most.
// Reset (rst_n low, synchronous) idles the sequencer and empties the output.
`timescale 1ns / 1ps

module integer_to_ascii_formatter #(
  parameter int VALUE_WIDTH = itaf_pkg::VALUE_WIDTH_DEF,
  parameter int MAX_DIGITS  = itaf_pkg::MAX_DIGITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  itaf_pkg::in_item_t   in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output itaf_pkg::out_item_t  out_item
);
  import itaf_pkg::*;

  localparam int NDEC = dec_digits(VALUE_WIDTH);

  digit_cmd_t             cmd;
  logic [VALUE_WIDTH-1:0] load_val;
  logic [3:0]             top_digit;

  itaf_ctrl #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .MAX_DIGITS  (MAX_DIGITS),
    .NDEC        (NDEC)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .cmd       (cmd),
    .load_val  (load_val),
    .top_digit (top_digit)
  );

  itaf_digits #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDEC        (NDEC)
  ) u_digits (
    .clk       (clk),
    .cmd       (cmd),
    .load_val  (load_val),
    .top_digit (top_digit)
  );

endmodule

@@ rtl/core/itaf_checker.sv @@
// Port-level checks on the formatter, bound to the top level.
// Uses itaf_pkg and integer_to_ascii_formatter_macros.svh.
`timescale 1ns / 1ps
`include "integer_to_ascii_formatter_macros.svh"

module itaf_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input itaf_pkg::in_item_t   in_item,
  input logic                 out_valid,
  input logic                 out_stall,
  input itaf_pkg::out_item_t  out_item
);
  import itaf_pkg::*;

  // A stalled result holds.
  `ITAF_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))

  // One request at a time: intake closes straight after a transfer.
  `ITAF_ASSERT_NEXT(a_one_req, clk, rst_n, in_valid && !in_stall, in_stall)

  // Only a minus sign or a digit can be followed by more characters.
  `ITAF_ASSERT_NOW(a_mid_char, clk, rst_n, out_valid && !out_item.last, (out_item.out_char == CHR_MINUS) || ((out_item.out_char >= 8'h30) && (out_item.out_char <= 8'h39)) || ((out_item.out_char >= 8'h61) && (out_item.out_char <= 8'h66)))

  // A byte request with an empty output shows its byte, marked last, in the output register after the sign state.
  `ITAF_ASSERT_NEXT(a_byte_pass, clk, rst_n, in_valid && !in_stall && (in_item.action == ACT_BYTE) && !out_valid, ##1 (out_valid && out_item.last && (out_item.out_char == $past(in_item.char_byte, 2))))

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (.*);
